[hdl/ibc_pkg.sv]
package ibc_pkg;

   localparam int CoordFracBits = 16;
   localparam int CoefFrac      = 28;
   localparam int QuotWidth     = 60;

   typedef enum logic [2:0] {
      REG_ENABLE = 3'd0,
      REG_K1     = 3'd1,
      REG_K2     = 3'd2,
      REG_P1     = 3'd3,
      REG_P2     = 3'd4,
      REG_K3     = 3'd5
   } reg_index_type;

   // saturating narrow of a 66-bit signed value to 32 bits
   function automatic logic [32:0] sat32(input logic signed [65:0] v);
      logic [32:0] r;
      if (v > 66'sd2147483647) begin
         r = {1'b1, 32'h7fff_ffff};
      end else if (v < -66'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   // round a 64-bit product by 28 bits, ties up, then saturate
   function automatic logic [32:0] qround(input logic signed [63:0] p);
      logic signed [65:0] t;
      t = ($signed({{2{p[63]}}, p}) + 66'sd134217728) >>> CoefFrac;
      return sat32(t);
   endfunction

endpackage

[hdl/ibc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Divides |num| << 28 by |den|, truncated toward zero, sign applied at the end.
module ibc_div (
   input  logic                clock,
   input  logic                enable,
   input  logic signed [31:0]  num,
   input  logic signed [31:0]  den,
   output logic [32:0]         quot
);
   import ibc_pkg::*;

   localparam int Steps = QuotWidth;

   logic [Steps-1:0]  dvd_ff [1:Steps];
   logic [Steps-1:0]  qt_ff  [1:Steps];
   logic [32:0]       rem_ff [1:Steps];
   logic [31:0]       dvs_ff [1:Steps];
   logic              neg_ff [1:Steps];
   logic [32:0]       quot_ff;
   logic signed [61:0] sq;
   logic [Steps-1:0]  dvd_0;
   logic [31:0]       dvs_0;
   logic              neg_0;

   // operand magnitudes and result sign
   always_comb begin
      dvd_0 = {28'd0, num[31] ? 32'(-num) : num} << CoefFrac;
      dvs_0 = den[31] ? 32'(-den) : den;
      neg_0 = num[31] ^ den[31];
   end

   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic [Steps-1:0] dvd_i;
      logic [Steps-1:0] qt_i;
      logic [32:0]      rem_i;
      logic [31:0]      dvs_i;
      logic             neg_i;
      logic [33:0]      shl;
      logic [33:0]      dif;
      if (s == 0) begin : g_first
         assign dvd_i = dvd_0;
         assign qt_i  = '0;
         assign rem_i = '0;
         assign dvs_i = dvs_0;
         assign neg_i = neg_0;
      end else begin : g_next
         assign dvd_i = dvd_ff[s];
         assign qt_i  = qt_ff[s];
         assign rem_i = rem_ff[s];
         assign dvs_i = dvs_ff[s];
         assign neg_i = neg_ff[s];
      end
      always_comb begin
         shl = {rem_i, dvd_i[Steps-1]};
         dif = shl - {2'b0, dvs_i};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            dvd_ff[s+1] <= dvd_i << 1;
            dvs_ff[s+1] <= dvs_i;
            neg_ff[s+1] <= neg_i;
            if (!dif[33]) begin
               rem_ff[s+1] <= dif[32:0];
               qt_ff[s+1]  <= {qt_i[Steps-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= shl[32:0];
               qt_ff[s+1]  <= {qt_i[Steps-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      sq = neg_ff[Steps] ? -$signed({2'b0, qt_ff[Steps]}) : $signed({2'b0, qt_ff[Steps]});
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quot_ff <= sat32(66'(sq));
      end
   end

   assign quot = quot_ff;
endmodule

[hdl/inverse_brown_conrady_undistort.sv]
// Channel | Ports      | Word (low bit first)
// req     | req_t*     | tdata: point_x, point_y, point_z
// rsp     | rsp_t*     | tdata: out_x, out_y, out_z; tuser: zero_depth, saturated
// csr     | csr_*      | write only, index 0..5
// One point per clock; the path is the divider depth (61) plus 9 math stages plus
// the output register. The whole pipe advances when the output slot is free or taken.
// Synchronous reset clears valid bits and the registers; data registers are not reset.
module inverse_brown_conrady_undistort #(
   parameter int COORD_FRAC_BITS = ibc_pkg::CoordFracBits
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // point_x, point_y, point_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // out_x, out_y, out_z
   output logic [1:0]   rsp_tuser,   // zero_depth, saturated
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import ibc_pkg::*;

   localparam int DivLat = QuotWidth + 1;
   localparam int Lat    = DivLat + 9;

   // format is shared by x, y and z, so the fraction width does not reach the math
   logic [COORD_FRAC_BITS-1:0] unused_frac;
   assign unused_frac = '0;

   logic               en_ff;
   logic signed [31:0] k1_ff, k2_ff, k3_ff, p1_ff, p2_ff;
   logic               adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0; k1_ff <= '0; k2_ff <= '0; k3_ff <= '0; p1_ff <= '0; p2_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ENABLE: en_ff <= csr_data[0];
            REG_K1:     k1_ff <= csr_data;
            REG_K2:     k2_ff <= csr_data;
            REG_P1:     p1_ff <= csr_data;
            REG_P2:     p2_ff <= csr_data;
            REG_K3:     k3_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   logic signed [31:0] ix, iy, iz;
   assign ix = req_tdata[31:0];
   assign iy = req_tdata[63:32];
   assign iz = req_tdata[95:64];

   // --- dividers
   logic [32:0] xn_q, yn_q;
   ibc_div u_divx (.clock, .enable(adv), .num(ix), .den(iz), .quot(xn_q));
   ibc_div u_divy (.clock, .enable(adv), .num(iy), .den(iz), .quot(yn_q));

   // --- side delay line for inputs and valid
   logic [95:0] pt_ff [Lat];
   logic        vl_ff [Lat];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Lat; i++) vl_ff[i] <= 1'b0;
      end else if (adv) begin
         vl_ff[0] <= req_tvalid;
         for (int i = 1; i < Lat; i++) vl_ff[i] <= vl_ff[i-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         pt_ff[0] <= req_tdata;
         for (int i = 1; i < Lat; i++) pt_ff[i] <= pt_ff[i-1];
      end
   end

   // math stages, s1..s9; each carries the saturation flag
   logic signed [31:0] a_xn_ff, a_yn_ff, a_xx_ff, a_yy_ff, a_xy_ff;
   logic signed [31:0] b_xn_ff, b_yn_ff, b_xx_ff, b_yy_ff, b_xy_ff, b_r2_ff;
   logic signed [31:0] c_xn_ff, c_yn_ff, c_xy_ff, c_r2_ff, c_r4_ff, c_cx_ff, c_cy_ff;
   logic signed [31:0] d_xn_ff, d_yn_ff, d_xy_ff, d_r2_ff, d_r4_ff, d_r6_ff, d_cx_ff,
                       d_cy_ff;
   logic signed [31:0] e_xn_ff, e_yn_ff, e_t1_ff, e_t2_ff, e_t3_ff;
   logic signed [31:0] e_pa_ff, e_pb_ff, e_pc_ff, e_pd_ff;
   logic signed [31:0] f_xn_ff, f_yn_ff, f_f_ff, f_pa_ff, f_pb_ff, f_pc_ff, f_pd_ff;
   logic signed [31:0] g_ax_ff, g_ay_ff, g_pa_ff, g_pb_ff, g_pc_ff, g_pd_ff;
   logic signed [31:0] h_ux_ff, h_uy_ff;
   logic signed [31:0] i_ox_ff, i_oy_ff;
   logic sa_ff, sb_ff, sc_ff, sd_ff, se_ff, sf_ff, sg_ff, sh_ff, si_ff;

   logic [32:0] m_xx, m_yy, m_xy, s_r2, m_r4, s_cx, s_cy, m_r6;
   logic [32:0] m_t1, m_t2, m_t3, m_pa, m_pb, m_pc, m_pd, s_f, m_ax, m_ay, s_ux, s_uy;
   logic [32:0] m_ox, m_oy;
   logic signed [31:0] z_h;

   always_comb begin
      m_xx = qround(64'($signed(xn_q[31:0])) * 64'($signed(xn_q[31:0])));
      m_yy = qround(64'($signed(yn_q[31:0])) * 64'($signed(yn_q[31:0])));
      m_xy = qround(64'($signed(xn_q[31:0])) * 64'($signed(yn_q[31:0])));
      s_r2 = sat32(66'(a_xx_ff) + 66'(a_yy_ff));
      m_r4 = qround(64'(b_r2_ff) * 64'(b_r2_ff));
      s_cx = sat32(66'(b_r2_ff) + 66'(b_xx_ff) * 66'sd2);
      s_cy = sat32(66'(b_r2_ff) + 66'(b_yy_ff) * 66'sd2);
      m_r6 = qround(64'(c_r4_ff) * 64'(c_r2_ff));
      m_t1 = qround(64'(k1_ff) * 64'(d_r2_ff));
      m_t2 = qround(64'(k2_ff) * 64'(d_r4_ff));
      m_t3 = qround(64'(k3_ff) * 64'(d_r6_ff));
      m_pa = qround(64'(p1_ff) * 64'(d_xy_ff));
      m_pb = qround(64'(p2_ff) * 64'(d_cx_ff));
      m_pc = qround(64'(p2_ff) * 64'(d_xy_ff));
      m_pd = qround(64'(p1_ff) * 64'(d_cy_ff));
      s_f  = sat32(66'sd268435456 + 66'(e_t1_ff) + 66'(e_t2_ff) + 66'(e_t3_ff));
      m_ax = qround(64'(f_xn_ff) * 64'(f_f_ff));
      m_ay = qround(64'(f_yn_ff) * 64'(f_f_ff));
      s_ux = sat32(66'(g_ax_ff) + 66'(g_pa_ff) * 66'sd2 + 66'(g_pb_ff));
      s_uy = sat32(66'(g_ay_ff) + 66'(g_pc_ff) * 66'sd2 + 66'(g_pd_ff));
      z_h  = pt_ff[DivLat+7][95:64];
      m_ox = qround(64'(h_ux_ff) * 64'(z_h));
      m_oy = qround(64'(h_uy_ff) * 64'(z_h));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_xn_ff <= xn_q[31:0]; a_yn_ff <= yn_q[31:0];
         a_xx_ff <= m_xx[31:0]; a_yy_ff <= m_yy[31:0]; a_xy_ff <= m_xy[31:0];
         sa_ff   <= xn_q[32] | yn_q[32] | m_xx[32] | m_yy[32] | m_xy[32];

         b_xn_ff <= a_xn_ff; b_yn_ff <= a_yn_ff; b_xx_ff <= a_xx_ff;
         b_yy_ff <= a_yy_ff; b_xy_ff <= a_xy_ff; b_r2_ff <= s_r2[31:0];
         sb_ff   <= sa_ff | s_r2[32];

         c_xn_ff <= b_xn_ff; c_yn_ff <= b_yn_ff; c_xy_ff <= b_xy_ff; c_r2_ff <= b_r2_ff;
         c_r4_ff <= m_r4[31:0]; c_cx_ff <= s_cx[31:0]; c_cy_ff <= s_cy[31:0];
         sc_ff   <= sb_ff | m_r4[32] | s_cx[32] | s_cy[32];

         d_xn_ff <= c_xn_ff; d_yn_ff <= c_yn_ff; d_xy_ff <= c_xy_ff; d_r2_ff <= c_r2_ff;
         d_r4_ff <= c_r4_ff; d_r6_ff <= m_r6[31:0]; d_cx_ff <= c_cx_ff; d_cy_ff <= c_cy_ff;
         sd_ff   <= sc_ff | m_r6[32];

         e_xn_ff <= d_xn_ff; e_yn_ff <= d_yn_ff;
         e_t1_ff <= m_t1[31:0]; e_t2_ff <= m_t2[31:0]; e_t3_ff <= m_t3[31:0];
         e_pa_ff <= m_pa[31:0]; e_pb_ff <= m_pb[31:0];
         e_pc_ff <= m_pc[31:0]; e_pd_ff <= m_pd[31:0];
         se_ff   <= sd_ff | m_t1[32] | m_t2[32] | m_t3[32] | m_pa[32] | m_pb[32]
                    | m_pc[32] | m_pd[32];

         f_xn_ff <= e_xn_ff; f_yn_ff <= e_yn_ff; f_f_ff <= s_f[31:0];
         f_pa_ff <= e_pa_ff; f_pb_ff <= e_pb_ff; f_pc_ff <= e_pc_ff; f_pd_ff <= e_pd_ff;
         sf_ff   <= se_ff | s_f[32];

         g_ax_ff <= m_ax[31:0]; g_ay_ff <= m_ay[31:0];
         g_pa_ff <= f_pa_ff; g_pb_ff <= f_pb_ff; g_pc_ff <= f_pc_ff; g_pd_ff <= f_pd_ff;
         sg_ff   <= sf_ff | m_ax[32] | m_ay[32];

         h_ux_ff <= s_ux[31:0]; h_uy_ff <= s_uy[31:0];
         sh_ff   <= sg_ff | s_ux[32] | s_uy[32];

         i_ox_ff <= m_ox[31:0]; i_oy_ff <= m_oy[31:0];
         si_ff   <= sh_ff | m_ox[32] | m_oy[32];
      end
   end

   // output register: pick corrected or passed-through point
   logic [95:0] pin;
   logic        zin;
   logic        rv_ff;
   logic [95:0] rd_ff;
   logic [1:0]  ru_ff;
   assign pin = pt_ff[Lat-1];
   assign zin = (pin[95:64] == 32'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (adv) begin
         rv_ff <= vl_ff[Lat-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         if (zin || !en_ff) begin
            rd_ff <= pin;
            ru_ff <= {1'b0, zin};
         end else begin
            rd_ff <= {pin[95:64], i_oy_ff, i_ox_ff};
            ru_ff <= {si_ff, 1'b0};
         end
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tuser  = ru_ff;
endmodule

[hdl/ibc_check.sv]
module ibc_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   // a held result word stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed under stall");
   // zero depth never comes with saturation
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("zero_depth and saturated both set");
   // zero depth flag matches the depth field
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tdata[95:64] == 32'd0)))
      else $error("zero_depth mismatch");
   // input is stalled only while a result is held
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output stall");
   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
   logic unused_v;
   assign unused_v = req_tvalid;
endmodule

bind inverse_brown_conrady_undistort ibc_check u_ibc_check (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .rsp_tuser
);

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
   import ibc_pkg::*;

   localparam int PipeDepth = 80;
   localparam int RandWords = 750;
   localparam longint CycleLimit = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;   // point_x, point_y, point_z
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;        // out_x, out_y, out_z
   logic [1:0]   rsp_tuser;        // zero_depth, saturated
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   typedef struct packed {
      logic [31:0] ox;
      logic [31:0] oy;
      logic [31:0] oz;
      logic        zero;
      logic        sat;
   } point_res_type;

   typedef struct {
      logic [31:0]   x;
      logic [31:0]   y;
      logic [31:0]   z;
      bit            has_res;
      point_res_type res;
   } point_row_type;

   // shadow of the lens registers
   logic        lens_on;
   logic signed [31:0] k1, k2, k3, p1, p2;

   point_res_type pending_q[$];
   int  mismatches = 0;
   int  results_seen = 0;
   longint cycles = 0;
   bit  calm = 1'b0;

   inverse_brown_conrady_undistort u_dut (.*);

   always #5 clock = ~clock;

   // cycle watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // ---- lens predictor ----
   bit clip;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) begin
         clip = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         clip = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint qprod(longint a, longint b);
      longint p;
      p = a * b + (64'sd1 <<< (CoefFrac - 1));
      return clamp32(p >>> CoefFrac);
   endfunction

   function automatic point_res_type undistort(logic [31:0] xi, logic [31:0] yi,
                                               logic [31:0] zi);
      point_res_type r;
      longint x, y, z, xn, yn, xx, yy, xy, r2, r4, r6, f, cx, cy, ux, uy;
      x = longint'(signed'(xi));
      y = longint'(signed'(yi));
      z = longint'(signed'(zi));
      clip = 1'b0;
      r.ox = xi;
      r.oy = yi;
      r.oz = zi;
      r.zero = (z == 0);
      if (z != 0 && lens_on) begin
         xn = clamp32((x <<< CoefFrac) / z);
         yn = clamp32((y <<< CoefFrac) / z);
         xx = qprod(xn, xn);
         yy = qprod(yn, yn);
         xy = qprod(xn, yn);
         r2 = clamp32(xx + yy);
         r4 = qprod(r2, r2);
         r6 = qprod(r4, r2);
         f  = clamp32((64'sd1 <<< CoefFrac) + qprod(k1, r2) + qprod(k2, r4)
                      + qprod(k3, r6));
         cx = clamp32(r2 + 2 * xx);
         cy = clamp32(r2 + 2 * yy);
         ux = clamp32(qprod(xn, f) + 2 * qprod(p1, xy) + qprod(p2, cx));
         uy = clamp32(qprod(yn, f) + 2 * qprod(p2, xy) + qprod(p1, cy));
         r.ox = 32'(qprod(ux, z));
         r.oy = 32'(qprod(uy, z));
      end
      r.sat = clip;
      return r;
   endfunction

   // ---- driver side ----
   task automatic req_gap();
      int n;
      if (!calm && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_point(point_row_type row);
      point_res_type e;
      req_gap();
      e = undistort(row.x, row.y, row.z);
      if (row.has_res) e = row.res;
      req_tdata  <= {row.z, row.y, row.x};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_q.push_back(e);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (PipeDepth) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_ENABLE: lens_on = v[0];
         REG_K1:     k1 = v;
         REG_K2:     k2 = v;
         REG_P1:     p1 = v;
         REG_P2:     p2 = v;
         REG_K3:     k3 = v;
         default: ;
      endcase
   endtask

   task automatic load_lens(logic en, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            logic [31:0] d, logic [31:0] e);
      write_reg(REG_ENABLE, {31'd0, en});
      write_reg(REG_K1, a);
      write_reg(REG_K2, b);
      write_reg(REG_P1, c);
      write_reg(REG_P2, d);
      write_reg(REG_K3, e);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 20000)) - 10000) <<< 6;
         default: return 32'($signed($urandom_range(0, 400000)) - 200000);
      endcase
   endfunction

   function automatic logic [31:0] rand_depth();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return $urandom();
         2: return 32'($signed($urandom_range(1, 40)) - 20);
         default: return 32'($signed($urandom_range(0, 1) ? 1 : -1)
                             * $signed($urandom_range(32768, 655360)));
      endcase
   endfunction

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
      endcase
   endfunction

   // ---- result checker ----
   always @(posedge clock) begin
      point_res_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                rsp_tuser[0], rsp_tuser[1]};
         results_seen++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("tb: unexpected result %p", got);
         end else begin
            want = pending_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("tb: mismatch exp %p got %p", want, got);
            end
         end
      end
      if (!reset && $urandom_range(0, 7) == 0 && !calm) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      rsp_tready <= 1'b1;
   end

   // ---- stimulus ----
   point_row_type directed[$];

   function automatic point_row_type mk(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      point_row_type r;
      r.x = x; r.y = y; r.z = z; r.has_res = 1'b0; r.res = '0;
      return r;
   endfunction

   function automatic point_row_type mk_known(logic [31:0] x, logic [31:0] y,
                                              logic [31:0] z, logic sat);
      point_row_type r;
      r = mk(x, y, z);
      r.has_res = 1'b1;
      r.res = '{x, y, z, z == 0, sat};
      return r;
   endfunction

   initial begin
      int phase;
      lens_on = 0; k1 = 0; k2 = 0; k3 = 0; p1 = 0; p2 = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset the lens is off: pass-through
      directed.push_back(mk_known(32'h0001_0000, 32'hffff_0000, 32'h0002_0000, 0));
      directed.push_back(mk_known(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0));
      directed.push_back(mk_known(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0));
      directed.push_back(mk_known(32'h1234_5678, 32'hdead_beef, 32'h0, 0));
      foreach (directed[i]) send_point(directed[i]);
      drain();

      // correction on, mild lens; zero depth and extremes
      load_lens(1, 32'hfc00_0000, 32'h0080_0000, 32'h0010_0000, 32'hfff0_0000,
                32'hffc0_0000);
      directed.delete();
      directed.push_back(mk_known(32'h0003_0000, 32'h0004_0000, 32'h0, 0));
      directed.push_back(mk_known(32'h8000_0000, 32'h7fff_ffff, 32'h0, 0));
      directed.push_back(mk(32'h0, 32'h0, 32'h0001_0000));
      directed.push_back(mk(32'h0000_8000, 32'hffff_8000, 32'h0002_0000));
      directed.push_back(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001));
      directed.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'hffff_ffff));
      directed.push_back(mk(32'h8000_0000, 32'h0, 32'h8000_0000));
      directed.push_back(mk(32'h7fff_ffff, 32'h0001_0000, 32'h7fff_ffff));
      directed.push_back(mk(32'hfffe_0000, 32'h0003_0000, 32'hfffc_0000));
      directed.push_back(mk(32'h0000_0001, 32'hffff_ffff, 32'h0010_0000));
      foreach (directed[i]) send_point(directed[i]);
      drain();

      // coefficient extremes
      load_lens(1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h7fff_ffff);
      send_point(mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
      send_point(mk(32'h0000_4000, 32'hffff_c000, 32'h0001_0000));
      send_point(mk(32'h0100_0000, 32'hff00_0000, 32'h0000_0100));
      drain();

      // random phases, each with a fresh lens setting
      for (phase = 0; phase < 6; phase++) begin
         if (phase == 5) calm = 1'b1;
         if (phase == 0)
            load_lens(0, rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
         else
            load_lens($urandom_range(0, 4) != 0, rand_coef(), rand_coef(), rand_coef(),
                      rand_coef(), rand_coef());
         repeat (RandWords / 6) send_point(mk(rand_coord(), rand_coord(), rand_depth()));
         drain();
      end

      $display("tb: %0d results checked over directed cases and six random lens settings",
               results_seen);
      $display("tb: %0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
hdl/ibc_pkg.sv
hdl/ibc_div.sv
hdl/inverse_brown_conrady_undistort.sv
hdl/ibc_check.sv
tb/sv/tb.sv
